// File: src/match_port_offset_filter_defines.svh
// ----------------------------------------------------------------------------
// match_port_offset_filter_defines
// Assertion macros used by the file that carries the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef MATCH_PORT_OFFSET_FILTER_DEFINES_SVH
`define MATCH_PORT_OFFSET_FILTER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define MPOF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("match_port_offset_filter check failed");

// Next-cycle implication, also checked across reset.
`define MPOF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("match_port_offset_filter check failed");

`endif

// File: src/mpof_pkg.sv
// ----------------------------------------------------------------------------
// mpof_pkg
// Types and constants of the match port and offset filter.
// ----------------------------------------------------------------------------
package mpof_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_HEADER = 2'd2,
    OP_MATCH  = 2'd3
  } op_t;

  localparam logic [1:0] OFF_NONE    = 2'd0;
  localparam logic [1:0] OFF_WITHIN  = 2'd1;
  localparam logic [1:0] OFF_ATLEAST = 2'd2;
  localparam logic [1:0] OFF_EXACT   = 2'd3;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] rule_id;
    logic [7:0]  proto;
    logic        req_dir;
    logic [15:0] port;
    logic [15:0] sport;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [1:0]  off_mode;
    logic [15:0] offset_value;
    logic [15:0] body_len;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_rule_id;
    logic [15:0] out_match_start;
    logic        kept;
    logic        stored;
    logic [15:0] kept_count;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rule_id;
    logic [7:0]  proto;
    logic        req_dir;
    logic [15:0] port;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [1:0]  off_mode;
    logic [15:0] offset_value;
  } rule_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] body_len;
  } header_t;

  typedef struct packed {
    op_t         op;
    rule_t       rule;
    header_t     header;
    logic        last;
  } cmd_t;

  typedef enum logic {
    B_IDLE   = 1'b0,
    B_SEARCH = 1'b1
  } back_state_t;

endpackage

// File: src/mpof_if.sv
// ----------------------------------------------------------------------------
// mpof_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mpof_in_if;
  import mpof_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mpof_out_if;
  import mpof_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/mpof_ram.sv
// ----------------------------------------------------------------------------
// mpof_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/mpof_front.sv
// ----------------------------------------------------------------------------
// mpof_front
// Accepts input items, sorts them into commands and queues them.
// ----------------------------------------------------------------------------
module mpof_front (
  input  logic          clk,
  input  logic          rst,
  mpof_in_if.sink       items,
  output mpof_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_pop
);
  import mpof_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in                    = '0;
    cmd_in.op                 = op_t'(items.data.opcode);
    cmd_in.last               = items.data.last;
    unique case (op_t'(items.data.opcode))
      OP_LOAD: begin
        cmd_in.rule.rule_id      = items.data.rule_id;
        cmd_in.rule.proto        = items.data.proto;
        cmd_in.rule.req_dir      = items.data.req_dir;
        cmd_in.rule.port         = items.data.port;
        cmd_in.rule.msg_type     = items.data.msg_type;
        cmd_in.rule.msg_code     = items.data.msg_code;
        cmd_in.rule.off_mode     = items.data.off_mode;
        cmd_in.rule.offset_value = items.data.offset_value;
      end
      OP_HEADER: begin
        cmd_in.header.proto    = items.data.proto;
        cmd_in.header.dport    = items.data.port;
        cmd_in.header.sport    = items.data.sport;
        cmd_in.header.msg_type = items.data.msg_type;
        cmd_in.header.msg_code = items.data.msg_code;
        cmd_in.header.body_len = items.data.body_len;
      end
      OP_MATCH: begin
        cmd_in.rule.rule_id      = items.data.rule_id;
        cmd_in.rule.offset_value = items.data.offset_value;
      end
      default: begin
        cmd_in.rule = '0;
      end
    endcase
  end

  assign items.ready = (fill != 2'd2);
  assign push        = items.valid && items.ready;
  assign cmd_valid   = (fill != 2'd0);
  assign cmd         = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/mpof_back.sv
// ----------------------------------------------------------------------------
// mpof_back
// Executes queued commands: rule table upkeep, packet header latch and the
// serial rule search with group and offset checks for each candidate.
// ----------------------------------------------------------------------------
module mpof_back #(
  parameter int MAX_RULES = 256,
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  localparam int TW = $clog2(MAX_RULES + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  mpof_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  logic [15:0]    output_cap,
  mpof_out_if.source     results
);
  import mpof_pkg::*;

  localparam int RW = $bits(rule_t);

  back_state_t state;
  back_state_t state_next;
  logic [AW-1:0] idx;
  logic [TW-1:0] total;
  header_t       pkt;
  logic [15:0]   kept_cnt;
  logic [15:0]   cand_id;
  logic [15:0]   cand_start;
  logic          cand_last;
  logic          out_valid;
  out_item_t     out_data;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;
  rule_t         rule;

  logic          out_free;
  logic          hit;
  logic          at_end;
  logic          done;
  logic          emit;
  logic          advance;
  logic          start_search;
  logic          group_ok;
  logic          offset_ok;
  logic          kept;
  logic [15:0]   limit;
  logic [15:0]   port_sel;
  logic [15:0]   kept_cnt_next;
  out_item_t     res;

  mpof_ram #(.WIDTH(RW), .DEPTH(MAX_RULES)) u_rules (
    .clk   (clk),
    .we    (ram_we),
    .waddr (total[AW-1:0]),
    .wdata (cmd.rule),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rule     = rule_t'(ram_rdata);
  assign out_free = !out_valid || results.ready;
  assign hit      = (rule.rule_id == cand_id);
  assign at_end   = ((TW'(idx) + TW'(1)) == total);
  assign done     = hit || at_end;

  always_comb begin
    port_sel = rule.req_dir ? pkt.dport : pkt.sport;
    if (rule.proto != pkt.proto) begin
      group_ok = 1'b0;
    end else if (rule.proto == PROTO_TCP || rule.proto == PROTO_UDP) begin
      group_ok = (port_sel == rule.port);
    end else if (rule.proto == PROTO_ICMP || rule.proto == PROTO_ICMPV6) begin
      group_ok = (rule.msg_type == pkt.msg_type) && (rule.msg_code == pkt.msg_code);
    end else begin
      group_ok = 1'b1;
    end
  end

  always_comb begin
    limit = (pkt.body_len < rule.offset_value) ? pkt.body_len : rule.offset_value;
    unique case (rule.off_mode)
      OFF_WITHIN:  offset_ok = (cand_start <= limit);
      OFF_ATLEAST: offset_ok = (cand_start >= rule.offset_value);
      OFF_EXACT:   offset_ok = (cand_start == rule.offset_value);
      default:     offset_ok = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (start_search) begin
          state_next = B_SEARCH;
        end
      end
      B_SEARCH: begin
        if (emit) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    emit         = 1'b0;
    advance      = 1'b0;
    start_search = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = '0;
    kept         = 1'b0;
    res          = '0;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op != OP_MATCH) begin
            cmd_pop = 1'b1;
            ram_we  = (cmd.op == OP_LOAD) && (total < TW'(MAX_RULES));
          end else if (total != '0) begin
            cmd_pop      = 1'b1;
            start_search = 1'b1;
          end else if (out_free) begin
            cmd_pop = 1'b1;
            emit    = 1'b1;
          end
        end
        res.out_rule_id     = cmd.rule.rule_id;
        res.out_match_start = cmd.rule.offset_value;
        res.out_last        = cmd.last;
      end
      B_SEARCH: begin
        if (!done) begin
          advance   = 1'b1;
          ram_raddr = idx + AW'(1);
        end else begin
          ram_raddr = idx;
          emit      = out_free;
        end
        kept                = hit && group_ok && offset_ok;
        res.out_rule_id     = cand_id;
        res.out_match_start = cand_start;
        res.out_last        = cand_last;
      end
      default: ram_raddr = '0;
    endcase
    kept_cnt_next  = (kept && kept_cnt != COUNT_MAX) ? kept_cnt + 16'd1 : kept_cnt;
    res.kept       = kept;
    res.stored     = kept && (kept_cnt < output_cap);
    res.kept_count = kept_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      total     <= '0;
      pkt       <= '0;
      kept_cnt  <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_search) begin
        idx <= '0;
      end else if (advance) begin
        idx <= idx + AW'(1);
      end
      if (cmd_pop && cmd.op == OP_CLEAR) begin
        total <= '0;
      end else if (ram_we) begin
        total <= total + TW'(1);
      end
      if (cmd_pop && cmd.op == OP_HEADER) begin
        pkt      <= cmd.header;
        kept_cnt <= 16'd0;
      end else if (emit) begin
        kept_cnt <= kept_cnt_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_search) begin
      cand_id    <= cmd.rule.rule_id;
      cand_start <= cmd.rule.offset_value;
      cand_last  <= cmd.last;
    end
    if (emit) begin
      out_data <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

// File: src/match_port_offset_filter.sv
// ----------------------------------------------------------------------------
// match_port_offset_filter
// Post-filters pattern-match candidates of a packet against a rule table.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake       Moves
// items     in   valid/ready     one request: clear, load, header or candidate
// results   out  valid/ready     one judged candidate
// APB       in   psel/penable    write or read of output_cap
//
// Clear, load and header requests are executed straight from idle. A candidate
// is searched serially, rule by rule, up to the first rule with its id or the
// end of the table; with an empty table it is judged without a search.
// A two-entry queue decouples intake from the serial search.
// Reset is synchronous; the table needs no clearing pass after it.
// A stalled result holds in its output register while intake goes on.
// ----------------------------------------------------------------------------
`include "match_port_offset_filter_defines.svh"

module match_port_offset_filter #(
  parameter int MAX_RULES = 256
) (
  input  logic        clk,
  input  logic        rst,
  mpof_in_if.sink     items,
  mpof_out_if.source  results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpof_pkg::*;

  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  logic [15:0] output_cap;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, output_cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_cap <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      output_cap <= pwdata[15:0];
    end
  end

  mpof_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mpof_back #(.MAX_RULES(MAX_RULES)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .output_cap (output_cap),
    .results    (results)
  );

  `MPOF_ASSERT_IMPL(a_stored_kept, results.valid && results.data.stored, results.data.kept)
  `MPOF_ASSERT_IMPL(a_kept_count, results.valid && results.data.kept, results.data.kept_count != 16'd0)
  `MPOF_ASSERT_NEXT(a_reset_out, rst, !results.valid)
  `MPOF_ASSERT_IMPL(a_pop_valid, cmd_pop, cmd_valid)

endmodule

// File: verif/mpof_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// mpof_scoreboard_pkg
// Verdict predictor and checker for the match port and offset filter bench.
// It keeps its own rule table, packet header and kept count, works out the
// verdict of every accepted candidate and compares results in order.
// ----------------------------------------------------------------------------
package mpof_scoreboard_pkg;

  import mpof_pkg::*;

  localparam int TABLE_DEPTH = 256;

  class verdict_scoreboard;

    rule_t       rules [TABLE_DEPTH];
    int unsigned rule_total;
    header_t     pkt;
    logic [15:0] kept_count;
    logic [15:0] output_cap;
    out_item_t   pending_verdicts [$];
    int unsigned errors;

    function new();
      rule_total = 0;
      pkt        = '0;
      kept_count = '0;
      output_cap = CAP_RESET;
      errors     = 0;
    endfunction

    function bit idle();
      return pending_verdicts.size() == 0;
    endfunction

    function void note_request(in_item_t it);
      out_item_t   v;
      rule_t       r;
      bit          found;
      bit          pass;
      logic [15:0] lim;
      found = 1'b0;
      r     = '0;
      case (op_t'(it.opcode))
        OP_CLEAR: begin
          rule_total = 0;
        end
        OP_LOAD: begin
          if (rule_total < TABLE_DEPTH) begin
            r.rule_id      = it.rule_id;
            r.proto        = it.proto;
            r.req_dir      = it.req_dir;
            r.port         = it.port;
            r.msg_type     = it.msg_type;
            r.msg_code     = it.msg_code;
            r.off_mode     = it.off_mode;
            r.offset_value = it.offset_value;
            rules[rule_total] = r;
            rule_total++;
          end
        end
        OP_HEADER: begin
          pkt.proto    = it.proto;
          pkt.dport    = it.port;
          pkt.sport    = it.sport;
          pkt.msg_type = it.msg_type;
          pkt.msg_code = it.msg_code;
          pkt.body_len = it.body_len;
          kept_count   = '0;
        end
        default: begin
          for (int i = 0; i < rule_total && !found; i++) begin
            if (rules[i].rule_id == it.rule_id) begin
              r     = rules[i];
              found = 1'b1;
            end
          end
          pass = found && (r.proto == pkt.proto);
          if (pass) begin
            case (r.proto) inside
              PROTO_TCP, PROTO_UDP: begin
                pass = ((r.req_dir ? pkt.dport : pkt.sport) == r.port);
              end
              PROTO_ICMP, PROTO_ICMPV6: begin
                pass = ({r.msg_type, r.msg_code} == {pkt.msg_type, pkt.msg_code});
              end
              default: ;
            endcase
          end
          if (pass) begin
            case (r.off_mode)
              OFF_WITHIN: begin
                lim  = (pkt.body_len < r.offset_value) ? pkt.body_len : r.offset_value;
                pass = (it.offset_value <= lim);
              end
              OFF_ATLEAST: pass = (it.offset_value >= r.offset_value);
              OFF_EXACT:   pass = (it.offset_value == r.offset_value);
              default: ;
            endcase
          end
          v.out_rule_id     = it.rule_id;
          v.out_match_start = it.offset_value;
          v.kept            = pass;
          v.stored          = pass && (kept_count < output_cap);
          if (pass && kept_count != COUNT_MAX) begin
            kept_count = kept_count + 16'd1;
          end
          v.kept_count = kept_count;
          v.out_last   = it.last;
          pending_verdicts.push_back(v);
        end
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result for rule id %0d arrived with no candidate pending", got.out_rule_id);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      compare_field("out_rule_id", want.out_rule_id, got.out_rule_id);
      compare_field("out_match_start", want.out_match_start, got.out_match_start);
      compare_field("kept", 16'(want.kept), 16'(got.kept));
      compare_field("stored", 16'(want.stored), 16'(got.stored));
      compare_field("kept_count", want.kept_count, got.kept_count);
      compare_field("out_last", 16'(want.out_last), 16'(got.out_last));
    endfunction

  endclass

endpackage

// File: verif/tb_match_port_offset_filter.sv
// ----------------------------------------------------------------------------
// tb_match_port_offset_filter
// Self-checking bench for the match port and offset filter. A directed list
// covers every opcode, protocol class and offset mode, then random packet
// sessions run under several idle and stall mixes and output caps. A full
// table closes the run.
// ----------------------------------------------------------------------------
module tb_match_port_offset_filter;

  timeunit 1ns;
  timeprecision 1ps;

  import mpof_pkg::*;
  import mpof_scoreboard_pkg::*;

  localparam logic [2:0]  CAP_ADDR       = 3'd0;
  localparam int unsigned CYCLE_LIMIT    = 4000000;
  localparam int unsigned SETTLE_CYCLES  = 2 * TABLE_DEPTH + 16;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASE_ITEMS    = 130;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mpof_in_if  items_if ();
  mpof_out_if results_if ();

  verdict_scoreboard sb;
  rule_t             shelf [$];
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       cycle_count;
  int unsigned       sent_count;
  int unsigned       hold_requests;

  match_port_offset_filter #(
    .MAX_RULES(TABLE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The long hold-off is served here so the sender keeps pushing meanwhile.
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (rst) begin
        results_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      sb.check_result(results_if.data);
    end
  end

  function automatic in_item_t random_fields();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return in_item_t'(bits[$bits(in_item_t)-1:0]);
  endfunction

  task automatic send_request(in_item_t it);
    rule_t r;
    while ($urandom_range(99) < idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data  <= it;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    sb.note_request(it);
    sent_count++;
    case (op_t'(it.opcode))
      OP_CLEAR: shelf.delete();
      OP_LOAD: begin
        if (shelf.size() < TABLE_DEPTH) begin
          r.rule_id      = it.rule_id;
          r.proto        = it.proto;
          r.req_dir      = it.req_dir;
          r.port         = it.port;
          r.msg_type     = it.msg_type;
          r.msg_code     = it.msg_code;
          r.off_mode     = it.off_mode;
          r.offset_value = it.offset_value;
          shelf.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_clear();
    in_item_t it;
    it        = random_fields();
    it.opcode = OP_CLEAR;
    send_request(it);
  endtask

  task automatic send_load(logic [15:0] id, logic [7:0] proto, logic req, logic [15:0] port,
                           logic [7:0] itype, logic [7:0] icode, logic [1:0] mode,
                           logic [15:0] value);
    in_item_t it;
    it              = random_fields();
    it.opcode       = OP_LOAD;
    it.rule_id      = id;
    it.proto        = proto;
    it.req_dir      = req;
    it.port         = port;
    it.msg_type     = itype;
    it.msg_code     = icode;
    it.off_mode     = mode;
    it.offset_value = value;
    send_request(it);
  endtask

  task automatic send_header(logic [7:0] proto, logic [15:0] dst, logic [15:0] src,
                             logic [7:0] itype, logic [7:0] icode, logic [15:0] len);
    in_item_t it;
    it          = random_fields();
    it.opcode   = OP_HEADER;
    it.proto    = proto;
    it.port     = dst;
    it.sport    = src;
    it.msg_type = itype;
    it.msg_code = icode;
    it.body_len = len;
    send_request(it);
  endtask

  task automatic send_candidate(logic [15:0] id, logic [15:0] start, logic last);
    in_item_t it;
    it              = random_fields();
    it.opcode       = OP_MATCH;
    it.rule_id      = id;
    it.offset_value = start;
    it.last         = last;
    send_request(it);
  endtask

  task automatic drain_and_settle();
    items_if.valid <= 1'b0;
    while (!sb.idle()) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_output_cap(logic [15:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {16'd0, cap};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.output_cap = cap;
  endtask

  function automatic in_item_t random_rule();
    in_item_t it;
    it         = random_fields();
    it.opcode  = OP_LOAD;
    it.rule_id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(15));
    case ($urandom_range(4))
      0: it.proto = PROTO_TCP;
      1: it.proto = PROTO_UDP;
      2: it.proto = PROTO_ICMP;
      3: it.proto = PROTO_ICMPV6;
      default: ;
    endcase
    case ($urandom_range(3))
      0: it.port = 16'd0;
      1: it.port = 16'hFFFF;
      2: it.port = 16'd80;
      default: ;
    endcase
    if ($urandom_range(1) == 1) begin
      it.offset_value = 16'($urandom_range(64));
    end
    return it;
  endfunction

  // One packet: an optional table rebuild, a header that usually fits a
  // loaded rule, then candidates aimed at loaded ids and offset boundaries.
  task automatic run_packet();
    in_item_t    it;
    rule_t       r;
    int unsigned n;
    if (shelf.size() == 0 || $urandom_range(3) == 0) begin
      if ($urandom_range(2) != 0) send_clear();
      n = $urandom_range(1, 8);
      repeat (n) send_request(random_rule());
    end
    it        = random_fields();
    it.opcode = OP_HEADER;
    if (shelf.size() > 0 && $urandom_range(5) != 0) begin
      r           = shelf[$urandom_range(shelf.size() - 1)];
      it.proto    = r.proto;
      it.msg_type = r.msg_type;
      it.msg_code = r.msg_code;
      if (r.req_dir) begin
        it.port = r.port;
      end else begin
        it.sport = r.port;
      end
      case ($urandom_range(2))
        0: it.body_len = r.offset_value;
        1: it.body_len = r.offset_value + 16'($urandom_range(4)) - 16'd2;
        default: ;
      endcase
    end
    send_request(it);
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(11) == 0) send_request(random_fields());
      it        = random_fields();
      it.opcode = OP_MATCH;
      if (shelf.size() > 0 && $urandom_range(4) != 0) begin
        r          = shelf[$urandom_range(shelf.size() - 1)];
        it.rule_id = r.rule_id;
        case ($urandom_range(4))
          0: it.offset_value = r.offset_value;
          1: it.offset_value = r.offset_value + 16'd1;
          2: it.offset_value = r.offset_value - 16'd1;
          3: it.offset_value = 16'($urandom_range(64));
          default: ;
        endcase
      end
      it.last = logic'((k == n - 1) ^ ($urandom_range(9) == 0));
      send_request(it);
    end
  endtask

  task automatic run_phase(int unsigned src, int unsigned snk, logic [15:0] cap,
                           bit hold, bit pause);
    int unsigned target;
    int unsigned mid;
    drain_and_settle();
    idle_pct  = src;
    stall_pct = snk;
    write_output_cap(cap);
    target = sent_count + PHASE_ITEMS;
    mid    = sent_count + PHASE_ITEMS / 2;
    while (sent_count < target) begin
      run_packet();
      if (sent_count >= mid) begin
        if (hold) hold_requests++;
        if (pause) drain_and_settle();
        hold  = 1'b0;
        pause = 1'b0;
      end
    end
  endtask

  initial begin
    sb            = new();
    idle_pct      = 0;
    stall_pct     = 0;
    sent_count    = 0;
    hold_requests = 0;
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    items_if.valid <= 1'b0;
    items_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks run with the output cap at its reset value.
    send_clear();
    send_load(16'd1, PROTO_TCP, 1'b1, 16'd80, 8'd0, 8'd0, OFF_NONE, 16'd0);
    send_load(16'd2, PROTO_UDP, 1'b0, 16'd53, 8'd0, 8'd0, OFF_WITHIN, 16'd100);
    send_load(16'd3, PROTO_ICMP, 1'b0, 16'd0, 8'd8, 8'd0, OFF_ATLEAST, 16'd10);
    send_load(16'd4, PROTO_ICMPV6, 1'b1, 16'd0, 8'd128, 8'd255, OFF_EXACT, 16'hFFFF);
    send_load(16'hFFFF, 8'hFF, 1'b0, 16'd0, 8'd0, 8'd0, OFF_WITHIN, 16'd0);
    send_load(16'd1, 8'd0, 1'b0, 16'd0, 8'd0, 8'd0, OFF_NONE, 16'd0);
    send_load(16'd0, PROTO_TCP, 1'b0, 16'hFFFF, 8'd0, 8'd0, OFF_ATLEAST, 16'd0);
    send_header(PROTO_TCP, 16'd80, 16'hFFFF, 8'd0, 8'd0, 16'd50);
    send_candidate(16'd1, 16'd0, 1'b0);
    send_candidate(16'd0, 16'hFFFF, 1'b0);
    send_candidate(16'd2, 16'd5, 1'b0);
    send_candidate(16'd7, 16'd3, 1'b1);
    send_header(PROTO_UDP, 16'd0, 16'd53, 8'd0, 8'd0, 16'd200);
    send_candidate(16'd2, 16'd100, 1'b0);
    send_candidate(16'd2, 16'd101, 1'b1);
    send_header(PROTO_ICMP, 16'd0, 16'd0, 8'd8, 8'd0, 16'd0);
    send_candidate(16'd3, 16'd9, 1'b0);
    send_candidate(16'd3, 16'd10, 1'b1);
    send_header(PROTO_ICMPV6, 16'd0, 16'd0, 8'd128, 8'd255, 16'hFFFF);
    send_candidate(16'd4, 16'hFFFF, 1'b0);
    send_candidate(16'd4, 16'hFFFE, 1'b1);
    send_header(8'hFF, 16'd0, 16'd0, 8'd0, 8'd0, 16'hFFFF);
    send_candidate(16'hFFFF, 16'd0, 1'b0);
    send_candidate(16'hFFFF, 16'd1, 1'b1);

    run_phase(0, 0, 16'd2, 1'b1, 1'b0);
    run_phase(65, 0, 16'd0, 1'b0, 1'b0);
    run_phase(0, 65, 16'hFFFF, 1'b0, 1'b1);
    run_phase(11, 11, 16'($urandom_range(1, 12)), 1'b0, 1'b0);

    // Load past the end of the table; the extra rules must be ignored.
    drain_and_settle();
    send_clear();
    for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
      send_load(16'(i), 8'd200, 1'b0, 16'd0, 8'd0, 8'd0, OFF_NONE, 16'd0);
    end
    send_header(8'd200, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0);
    send_candidate(16'd0, 16'd0, 1'b0);
    send_candidate(16'd128, 16'd0, 1'b0);
    send_candidate(16'(TABLE_DEPTH - 1), 16'd0, 1'b0);
    send_candidate(16'(TABLE_DEPTH), 16'd0, 1'b0);
    send_candidate(16'(TABLE_DEPTH + 1), 16'd0, 1'b1);

    drain_and_settle();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: match_port_offset_filter.f
+incdir+src
src/mpof_pkg.sv
src/mpof_if.sv
src/mpof_ram.sv
src/mpof_front.sv
src/mpof_back.sv
src/match_port_offset_filter.sv
verif/mpof_scoreboard_pkg.sv
verif/tb_match_port_offset_filter.sv
